/* src/irr_pkg.sv */
package irr_pkg;

    // item operation codes
    localparam logic [1:0] OP_MAP      = 2'd0;
    localparam logic [1:0] OP_LOAD_OVR = 2'd1;
    localparam logic [1:0] OP_LOAD_CTL = 2'd2;

    // result status codes
    localparam logic [2:0] ST_MAPPED    = 3'd0;
    localparam logic [2:0] ST_NO_CTRL   = 3'd1;
    localparam logic [2:0] ST_UNCOVERED = 3'd2;
    localparam logic [2:0] ST_LOADED    = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // configuration register indexes
    localparam logic CFG_LAPIC_PRESENT = 1'b0;
    localparam logic CFG_BOOT_APIC_ID  = 1'b1;

    // two-bit override codes for polarity (flags 1:0) and trigger (flags 3:2)
    localparam logic [1:0] FLAG_FORCE_SET   = 2'b11;
    localparam logic [1:0] FLAG_FORCE_CLEAR = 2'b01;

    localparam logic [9:0]  REDIR_BASE = 10'h010;
    localparam logic [15:0] LO_POL_LOW = 16'h2000;
    localparam logic [15:0] LO_LEVEL   = 16'h8000;

    typedef struct packed {
        logic [7:0]  irq;
        logic [31:0] gsi;
        logic [3:0]  flags;
    } ovr_entry_t;

    typedef struct packed {
        logic [31:0] base;
        logic [8:0]  pins;
    } ctl_entry_t;

endpackage

/* src/irq_redirection_router.sv */
// channel | direction | handshake            | payload
// s_      | in        | s_valid / s_ready    | op, irq, vector, dest_id, trig_level,
//         |           |                      | pol_low, gsi, flags, pin_count
// m_      | out       | m_valid / m_ready    | status, controller_index, pin, entry_register,
//         |           |                      | low_word, high_word
// cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// load, unused op, or map with no controller: the item goes straight to the done state,
// which loads the result register. map: the overrides are scanned up to the first match,
// each as a registered read then a compare, then the controllers up to the first match;
// one shared 33-bit subtract tests a controller range per cycle.
// aresetn clears the fill counts, the registers and the sequencer; no clearing pass.
// s_ready is high only while idle; a held result stalls the next item in its last cycle.
module irq_redirection_router
    import irr_pkg::*;
#(
    parameter int OVERRIDE_SLOTS   = 16,
    parameter int CONTROLLER_SLOTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_irq,
    input  logic [7:0]  s_vector,
    input  logic [7:0]  s_dest_id,
    input  logic        s_trig_level,
    input  logic        s_pol_low,
    input  logic [31:0] s_gsi,
    input  logic [3:0]  s_flags,
    input  logic [8:0]  s_pin_count,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_controller_index,
    output logic [7:0]  m_pin,
    output logic [9:0]  m_entry_register,
    output logic [15:0] m_low_word,
    output logic [31:0] m_high_word,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int OCW = $clog2(OVERRIDE_SLOTS + 1);
    localparam int OIW = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
    localparam int CCW = $clog2(CONTROLLER_SLOTS + 1);
    localparam int CIW = (CONTROLLER_SLOTS > 1) ? $clog2(CONTROLLER_SLOTS) : 1;
    localparam logic [OCW-1:0] OVR_FULL = OCW'(OVERRIDE_SLOTS);
    localparam logic [CCW-1:0] CTL_FULL = CCW'(CONTROLLER_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVR_READ,
        S_OVR_CMP,
        S_CTL,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               lapic_present_reg, lapic_present_next;
    logic [7:0]         boot_apic_id_reg, boot_apic_id_next;
    logic [OCW-1:0]     ovr_count_reg, ovr_count_next;
    logic [CCW-1:0]     ctl_count_reg, ctl_count_next;
    logic [OCW-1:0]     ovr_idx_reg, ovr_idx_next;
    logic [CCW-1:0]     ctl_idx_reg, ctl_idx_next;

    // item being worked on
    logic [7:0]         irq_reg, irq_next;
    logic [7:0]         vector_reg, vector_next;
    logic [7:0]         dest_reg, dest_next;
    logic               level_reg, level_next;
    logic               low_reg, low_next;
    logic [31:0]        gsi_reg, gsi_next;
    logic [2:0]         st_reg, st_next;
    logic [1:0]         sel_reg, sel_next;
    logic [8:0]         offset_reg, offset_next;

    logic               m_valid_reg, m_valid_next;
    logic [2:0]         m_status_reg, m_status_next;
    logic [1:0]         m_ctl_reg, m_ctl_next;
    logic [7:0]         m_pin_reg, m_pin_next;
    logic [9:0]         m_entry_reg, m_entry_next;
    logic [15:0]        m_low_reg, m_low_next;
    logic [31:0]        m_high_reg, m_high_next;

    ovr_entry_t         ovr_mem [OVERRIDE_SLOTS];
    ovr_entry_t         ovr_rd_reg;
    logic               ovr_we;
    ctl_entry_t         ctl_tab_reg [CONTROLLER_SLOTS];
    logic               ctl_we;

    ctl_entry_t         ctl_cur;
    logic [32:0]        ctl_diff;
    logic               ctl_hit;
    logic [7:0]         dest_id;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_controller_index = m_ctl_reg;
    assign m_pin              = m_pin_reg;
    assign m_entry_register   = m_entry_reg;
    assign m_low_word         = m_low_reg;
    assign m_high_word        = m_high_reg;

    // shared range test: gsi - base at 33 bits, then offset below the pin count
    assign ctl_cur  = ctl_tab_reg[ctl_idx_reg[CIW-1:0]];
    assign ctl_diff = {1'b0, gsi_reg} - {1'b0, ctl_cur.base};
    assign ctl_hit  = !ctl_diff[32] && (ctl_diff[31:9] == 23'd0)
                      && (ctl_diff[8:0] < ctl_cur.pins);

    assign dest_id = (lapic_present_reg && dest_reg == 8'd0) ? boot_apic_id_reg : dest_reg;

    always_comb begin
        state_next         = state_reg;
        lapic_present_next = lapic_present_reg;
        boot_apic_id_next  = boot_apic_id_reg;
        ovr_count_next     = ovr_count_reg;
        ctl_count_next     = ctl_count_reg;
        ovr_idx_next       = ovr_idx_reg;
        ctl_idx_next       = ctl_idx_reg;
        irq_next           = irq_reg;
        vector_next        = vector_reg;
        dest_next          = dest_reg;
        level_next         = level_reg;
        low_next           = low_reg;
        gsi_next           = gsi_reg;
        st_next            = st_reg;
        sel_next           = sel_reg;
        offset_next        = offset_reg;
        m_valid_next       = m_valid_reg;
        m_status_next      = m_status_reg;
        m_ctl_next         = m_ctl_reg;
        m_pin_next         = m_pin_reg;
        m_entry_next       = m_entry_reg;
        m_low_next         = m_low_reg;
        m_high_next        = m_high_reg;
        ovr_we             = 1'b0;
        ctl_we             = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LAPIC_PRESENT: lapic_present_next = cfg_data[0];
                CFG_BOOT_APIC_ID:  boot_apic_id_next  = cfg_data;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    irq_next    = s_irq;
                    vector_next = s_vector;
                    dest_next   = s_dest_id;
                    level_next  = s_trig_level;
                    low_next    = s_pol_low;
                    gsi_next    = {24'd0, s_irq};
                    state_next  = S_DONE;
                    unique case (s_op)
                        OP_MAP: begin
                            if (ctl_count_reg == '0) begin
                                st_next = ST_NO_CTRL;
                            end else begin
                                ovr_idx_next = '0;
                                state_next   = S_OVR_READ;
                            end
                        end
                        OP_LOAD_OVR: begin
                            if (ovr_count_reg < OVR_FULL) begin
                                ovr_we         = 1'b1;
                                ovr_count_next = ovr_count_reg + 1'b1;
                                st_next        = ST_LOADED;
                            end else begin
                                st_next = ST_FULL;
                            end
                        end
                        OP_LOAD_CTL: begin
                            if (ctl_count_reg < CTL_FULL) begin
                                ctl_we         = 1'b1;
                                ctl_count_next = ctl_count_reg + 1'b1;
                                st_next        = ST_LOADED;
                            end else begin
                                st_next = ST_FULL;
                            end
                        end
                        default: st_next = ST_FULL;
                    endcase
                end
            end
            S_OVR_READ: begin
                // the read of entry ovr_idx lands in ovr_rd_reg at this edge
                if (ovr_idx_reg == ovr_count_reg) begin
                    ctl_idx_next = '0;
                    state_next   = S_CTL;
                end else begin
                    state_next = S_OVR_CMP;
                end
            end
            S_OVR_CMP: begin
                if (ovr_rd_reg.irq == irq_reg) begin
                    gsi_next = ovr_rd_reg.gsi;
                    if (ovr_rd_reg.flags[1:0] == FLAG_FORCE_SET) begin
                        low_next = 1'b1;
                    end else if (ovr_rd_reg.flags[1:0] == FLAG_FORCE_CLEAR) begin
                        low_next = 1'b0;
                    end
                    if (ovr_rd_reg.flags[3:2] == FLAG_FORCE_SET) begin
                        level_next = 1'b1;
                    end else if (ovr_rd_reg.flags[3:2] == FLAG_FORCE_CLEAR) begin
                        level_next = 1'b0;
                    end
                    ctl_idx_next = '0;
                    state_next   = S_CTL;
                end else begin
                    ovr_idx_next = ovr_idx_reg + 1'b1;
                    state_next   = S_OVR_READ;
                end
            end
            S_CTL: begin
                if (ctl_idx_reg == ctl_count_reg) begin
                    st_next    = ST_UNCOVERED;
                    state_next = S_DONE;
                end else if (ctl_hit) begin
                    st_next     = ST_MAPPED;
                    sel_next    = 2'(ctl_idx_reg);
                    offset_next = ctl_diff[8:0];
                    state_next  = S_DONE;
                end else begin
                    ctl_idx_next = ctl_idx_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    if (st_reg == ST_MAPPED) begin
                        m_ctl_next   = sel_reg;
                        m_pin_next   = offset_reg[7:0];
                        m_entry_next = REDIR_BASE + {offset_reg, 1'b0};
                        m_low_next   = {8'd0, vector_reg}
                                       | (low_reg ? LO_POL_LOW : 16'd0)
                                       | (level_reg ? LO_LEVEL : 16'd0);
                        m_high_next  = {dest_id, 24'd0};
                    end else begin
                        m_ctl_next   = 2'd0;
                        m_pin_next   = 8'd0;
                        m_entry_next = 10'd0;
                        m_low_next   = 16'd0;
                        m_high_next  = 32'd0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            lapic_present_reg <= 1'b0;
            boot_apic_id_reg  <= 8'd0;
            ovr_count_reg     <= '0;
            ctl_count_reg     <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            lapic_present_reg <= lapic_present_next;
            boot_apic_id_reg  <= boot_apic_id_next;
            ovr_count_reg     <= ovr_count_next;
            ctl_count_reg     <= ctl_count_next;
            m_valid_reg       <= m_valid_next;
        end
        ovr_idx_reg  <= ovr_idx_next;
        ctl_idx_reg  <= ctl_idx_next;
        irq_reg      <= irq_next;
        vector_reg   <= vector_next;
        dest_reg     <= dest_next;
        level_reg    <= level_next;
        low_reg      <= low_next;
        gsi_reg      <= gsi_next;
        st_reg       <= st_next;
        sel_reg      <= sel_next;
        offset_reg   <= offset_next;
        m_status_reg <= m_status_next;
        m_ctl_reg    <= m_ctl_next;
        m_pin_reg    <= m_pin_next;
        m_entry_reg  <= m_entry_next;
        m_low_reg    <= m_low_next;
        m_high_reg   <= m_high_next;
    end

    // override table, one write port at the fill count, registered read at the scan index
    always_ff @(posedge aclk) begin
        if (ovr_we) begin
            ovr_mem[ovr_count_reg[OIW-1:0]] <= '{irq: s_irq, gsi: s_gsi, flags: s_flags};
        end
        ovr_rd_reg <= ovr_mem[ovr_idx_reg[OIW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (ctl_we) begin
            ctl_tab_reg[ctl_count_reg[CIW-1:0]] <= '{base: s_gsi, pins: s_pin_count};
        end
    end

`ifndef SYNTHESIS
    a_ovr_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ovr_count_reg <= OVR_FULL)
        else $error("override fill count beyond table size");

    a_full_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_LOAD_OVR && ovr_count_reg == OVR_FULL)
        |=> ovr_count_reg == $past(ovr_count_reg))
        else $error("override load into full table changed the fill count");

    a_mapped_needs_ctl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_MAPPED) |-> ctl_count_reg != '0)
        else $error("mapped result with no controller loaded");

    a_fail_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_MAPPED)
        |-> (m_pin == 8'd0 && m_entry_register == 10'd0 && m_low_word == 16'd0
             && m_high_word == 32'd0 && m_controller_index == 2'd0))
        else $error("non-mapped result carries routing payload");

    a_scan_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OVR_CMP) |-> ovr_idx_reg < ovr_count_reg)
        else $error("override compare beyond fill count");
`endif

endmodule

/* bench/tb_irq_redirection_router.sv */
`default_nettype none

module tb_irq_redirection_router;
    import irr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OVERRIDE_SLOTS   = 16;
    localparam int CONTROLLER_SLOTS = 4;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 236;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  irq;
        logic [7:0]  vector;
        logic [7:0]  dest_id;
        logic        trig_level;
        logic        pol_low;
        logic [31:0] gsi;
        logic [3:0]  flags;
        logic [8:0]  pin_count;
    } route_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  controller_index;
        logic [7:0]  pin;
        logic [9:0]  entry_register;
        logic [15:0] low_word;
        logic [31:0] high_word;
    } route_resp_t;

    // routing tables as the block should hold them, plus the routes still owed
    class route_book;
        bit          lapic_on;
        logic [7:0]  boot_id;
        ovr_entry_t  overrides[$];
        ctl_entry_t  controllers[$];
        route_resp_t owed[$];
        int          mismatches;

        function void set_register(logic idx, logic [7:0] value);
            if (idx == CFG_LAPIC_PRESENT) begin
                lapic_on = value[0];
            end else begin
                boot_id = value;
            end
        endfunction

        function void note_request(route_req_t req);
            route_resp_t res;
            logic [31:0] target;
            logic [31:0] offset;
            logic        low;
            logic        level;
            logic [7:0]  dest;
            bit          matched;
            int          hit;
            res = '0;
            case (req.op)
                OP_MAP: begin
                    if (controllers.size() == 0) begin
                        res.status = ST_NO_CTRL;
                    end else begin
                        target = {24'd0, req.irq};
                        low = req.pol_low;
                        level = req.trig_level;
                        matched = 1'b0;
                        foreach (overrides[i]) begin
                            if (!matched && overrides[i].irq == req.irq) begin
                                matched = 1'b1;
                                target = overrides[i].gsi;
                                if (overrides[i].flags[1:0] == FLAG_FORCE_SET) low = 1'b1;
                                else if (overrides[i].flags[1:0] == FLAG_FORCE_CLEAR) low = 1'b0;
                                if (overrides[i].flags[3:2] == FLAG_FORCE_SET) level = 1'b1;
                                else if (overrides[i].flags[3:2] == FLAG_FORCE_CLEAR) level = 1'b0;
                            end
                        end
                        // range end computed at 33 bits so a window at the top does not wrap
                        hit = -1;
                        foreach (controllers[i]) begin
                            if (hit < 0 && {1'b0, target} >= {1'b0, controllers[i].base}
                                && {1'b0, target} < {1'b0, controllers[i].base}
                                                    + {24'd0, controllers[i].pins})
                                hit = i;
                        end
                        if (hit < 0) begin
                            res.status = ST_UNCOVERED;
                        end else begin
                            offset = target - controllers[hit].base;
                            dest = (lapic_on && req.dest_id == 8'd0) ? boot_id
                                                                     : req.dest_id;
                            res.status = ST_MAPPED;
                            res.controller_index = 2'(hit);
                            res.pin = offset[7:0];
                            res.entry_register = REDIR_BASE + {offset[8:0], 1'b0};
                            res.low_word = {8'd0, req.vector}
                                         | (low ? LO_POL_LOW : 16'h0000)
                                         | (level ? LO_LEVEL : 16'h0000);
                            res.high_word = {dest, 24'd0};
                        end
                    end
                end
                OP_LOAD_OVR: begin
                    if (overrides.size() < OVERRIDE_SLOTS) begin
                        overrides.push_back(ovr_entry_t'{irq: req.irq, gsi: req.gsi,
                                                         flags: req.flags});
                        res.status = ST_LOADED;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
                OP_LOAD_CTL: begin
                    if (controllers.size() < CONTROLLER_SLOTS) begin
                        controllers.push_back(ctl_entry_t'{base: req.gsi,
                                                           pins: req.pin_count});
                        res.status = ST_LOADED;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
                default: begin
                    res.status = ST_FULL;
                end
            endcase
            owed.push_back(res);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        task check_route(route_resp_t got);
            route_resp_t want;
            if (owed.size() == 0) begin
                report($sformatf("result with nothing outstanding, status %0d", got.status));
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.controller_index !== want.controller_index)
                report($sformatf("controller %0d, want %0d",
                                 got.controller_index, want.controller_index));
            if (got.pin !== want.pin)
                report($sformatf("pin %0d, want %0d", got.pin, want.pin));
            if (got.entry_register !== want.entry_register)
                report($sformatf("entry register %h, want %h",
                                 got.entry_register, want.entry_register));
            if (got.low_word !== want.low_word)
                report($sformatf("low word %h, want %h", got.low_word, want.low_word));
            if (got.high_word !== want.high_word)
                report($sformatf("high word %h, want %h", got.high_word, want.high_word));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [7:0]  s_irq;
    logic [7:0]  s_vector;
    logic [7:0]  s_dest_id;
    logic        s_trig_level;
    logic        s_pol_low;
    logic [31:0] s_gsi;
    logic [3:0]  s_flags;
    logic [8:0]  s_pin_count;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [1:0]  m_controller_index;
    logic [7:0]  m_pin;
    logic [9:0]  m_entry_register;
    logic [15:0] m_low_word;
    logic [31:0] m_high_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    bit idle_on;
    bit hold_req;

    route_book book = new();

    irq_redirection_router #(
        .OVERRIDE_SLOTS   (OVERRIDE_SLOTS),
        .CONTROLLER_SLOTS (CONTROLLER_SLOTS)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_irq              (s_irq),
        .s_vector           (s_vector),
        .s_dest_id          (s_dest_id),
        .s_trig_level       (s_trig_level),
        .s_pol_low          (s_pol_low),
        .s_gsi              (s_gsi),
        .s_flags            (s_flags),
        .s_pin_count        (s_pin_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_controller_index (m_controller_index),
        .m_pin              (m_pin),
        .m_entry_register   (m_entry_register),
        .m_low_word         (m_low_word),
        .m_high_word        (m_high_word),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic route_req_t make_req(logic [1:0] op, logic [7:0] irq,
                                            logic [7:0] vector, logic [7:0] dest,
                                            logic level, logic low, logic [31:0] gsi,
                                            logic [3:0] flags, logic [8:0] pins);
        return route_req_t'{op, irq, vector, dest, level, low, gsi, flags, pins};
    endfunction

    // aim override targets at the loaded windows, their edges, or anywhere
    function automatic logic [31:0] override_target();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($urandom_range(0, 15));
            2: return 32'h10 + 32'($urandom_range(0, 510));
            3: return 32'hFFFF_FF80 + 32'($urandom_range(0, 127));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_020E;
                    1: return 32'h0000_020F;
                    2: return 32'hFFFF_FF7F;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic route_req_t random_request();
        route_req_t  req;
        int unsigned pick;
        req.op = OP_MAP;
        req.irq = 8'($urandom);
        req.vector = 8'($urandom);
        req.dest_id = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        req.trig_level = 1'($urandom);
        req.pol_low = 1'($urandom);
        req.gsi = $urandom;
        req.flags = 4'($urandom);
        req.pin_count = 9'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
            if (book.overrides.size() != 0 && $urandom_range(0, 1) == 1)
                req.irq = book.overrides[$urandom_range(0, book.overrides.size() - 1)].irq;
        end else if (pick < 92) begin
            req.op = OP_LOAD_OVR;
            req.gsi = override_target();
            if ($urandom_range(0, 1) == 1) req.irq = 8'($urandom_range(0, 31));
        end else if (pick < 97) begin
            req.op = OP_LOAD_CTL;
        end else begin
            req.op = OP_UNUSED;
        end
        return req;
    endfunction

    // valid stays high into the next negedge unless rest lowers it
    task automatic send_item(route_req_t req);
        @(negedge aclk);
        s_valid = 1'b1;
        s_op = req.op;
        s_irq = req.irq;
        s_vector = req.vector;
        s_dest_id = req.dest_id;
        s_trig_level = req.trig_level;
        s_pol_low = req.pol_low;
        s_gsi = req.gsi;
        s_flags = req.flags;
        s_pin_count = req.pin_count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.note_request(req);
    endtask

    task automatic rest(int unsigned cycles);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic drain();
        rest(1);
        while (book.owed.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        book.set_register(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_item(random_request());
            // every third stretch of forty transfers runs without sender gaps
            if (idle_on && (i / 40) % 3 != 2 && $urandom_range(0, 5) == 0)
                rest($urandom_range(1, 17));
        end
    endtask

    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            book.check_route(route_resp_t'{m_status, m_controller_index, m_pin,
                                           m_entry_register, m_low_word, m_high_word});
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_MAP;
        s_irq = '0;
        s_vector = '0;
        s_dest_id = '0;
        s_trig_level = 1'b0;
        s_pol_low = 1'b0;
        s_gsi = '0;
        s_flags = '0;
        s_pin_count = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LAPIC_PRESENT;
        cfg_data = '0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // nothing loaded yet, then an unused op with every field at its top
        send_item(make_req(OP_MAP, 8'd5, 8'h31, 8'd7, 1'b0, 1'b0, 32'd0, 4'h0, 9'd1));
        send_item(make_req(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF,
                           4'hF, 9'h1FF));

        // empty window, wide window with pin wrap, window at the top of the space, low window
        send_item(make_req(OP_LOAD_CTL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_0000,
                           4'h0, 9'd0));
        send_item(make_req(OP_LOAD_CTL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_0010,
                           4'h0, 9'h1FF));
        send_item(make_req(OP_LOAD_CTL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'hFFFF_FF80,
                           4'h0, 9'd256));
        send_item(make_req(OP_LOAD_CTL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_0000,
                           4'h0, 9'd16));
        send_item(make_req(OP_LOAD_CTL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                           4'h0, 9'd1));

        // overrides spanning every polarity and trigger code, plus a shadowed repeat of irq 0
        send_item(make_req(OP_LOAD_OVR, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                           4'hF, 9'd0));
        send_item(make_req(OP_LOAD_OVR, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_020E,
                           4'h5, 9'd0));
        send_item(make_req(OP_LOAD_OVR, 8'd9, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_020F,
                           4'hA, 9'd0));
        send_item(make_req(OP_LOAD_OVR, 8'd200, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_0000,
                           4'h0, 9'd0));
        send_item(make_req(OP_LOAD_OVR, 8'd3, 8'd0, 8'd0, 1'b0, 1'b0, 32'hFFFF_FF7F,
                           4'h3, 9'd0));
        send_item(make_req(OP_LOAD_OVR, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_0005,
                           4'hC, 9'd0));
        send_item(make_req(OP_LOAD_OVR, 8'd128, 8'd0, 8'd0, 1'b0, 1'b0, 32'hFFFF_FF80,
                           4'h1, 9'd0));
        send_item(make_req(OP_LOAD_OVR, 8'd77, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_0110,
                           4'h4, 9'd0));

        send_item(make_req(OP_MAP, 8'd0, 8'hFF, 8'd0, 1'b0, 1'b0, 32'd0, 4'h0, 9'd0));
        send_item(make_req(OP_MAP, 8'd255, 8'h00, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF,
                           4'hF, 9'h1FF));
        send_item(make_req(OP_MAP, 8'd9, 8'h40, 8'd1, 1'b1, 1'b0, 32'd0, 4'h0, 9'd0));
        send_item(make_req(OP_MAP, 8'd200, 8'h41, 8'd0, 1'b1, 1'b1, 32'd0, 4'h0, 9'd0));
        send_item(make_req(OP_MAP, 8'd3, 8'h42, 8'd2, 1'b0, 1'b1, 32'd0, 4'h0, 9'd0));
        send_item(make_req(OP_MAP, 8'd128, 8'h43, 8'd3, 1'b1, 1'b1, 32'd0, 4'h0, 9'd0));
        send_item(make_req(OP_MAP, 8'd77, 8'h44, 8'd4, 1'b0, 1'b0, 32'd0, 4'h0, 9'd0));
        send_item(make_req(OP_MAP, 8'd15, 8'h45, 8'd0, 1'b0, 1'b1, 32'd0, 4'h0, 9'd0));
        send_item(make_req(OP_MAP, 8'd16, 8'h46, 8'd5, 1'b1, 1'b0, 32'd0, 4'h0, 9'd0));
        drain();

        // upper data bits are ignored by the presence register
        write_reg(CFG_LAPIC_PRESENT, 8'hFF);
        write_reg(CFG_BOOT_APIC_ID, 8'hFF);
        run_phase(PHASE_ITEMS);
        drain();

        write_reg(CFG_LAPIC_PRESENT, 8'h01);
        write_reg(CFG_BOOT_APIC_ID, 8'h00);
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);
        drain();

        write_reg(CFG_LAPIC_PRESENT, 8'hFE);
        write_reg(CFG_BOOT_APIC_ID, 8'hA5);
        run_phase(PHASE_ITEMS);
        drain();

        write_reg(CFG_LAPIC_PRESENT, 8'h01);
        write_reg(CFG_BOOT_APIC_ID, 8'($urandom));
        run_phase(PHASE_ITEMS);
        drain();

        write_reg(CFG_LAPIC_PRESENT, 8'($urandom));
        write_reg(CFG_BOOT_APIC_ID, 8'($urandom));
        idle_on = 1'b0;
        run_phase(PHASE_ITEMS);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (book.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* irq_redirection_router.f */
src/irr_pkg.sv
src/irq_redirection_router.sv
bench/tb_irq_redirection_router.sv
